// ===== hdl/assert_macros.svh =====
// Assertion shorthands used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset
`define ASSERT_NOW(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, masked during reset
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/bclru_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bclru_pkg;

  localparam int NUM_BUFFERS_DEF = 32;
  localparam int DEV_W  = 16;
  localparam int BLK_W  = 32;
  localparam int CNT_W  = 8;
  localparam int SLOT_W = 5;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_GET,
    OP_RELEASE,
    OP_PIN,
    OP_UNPIN
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK,
    ST_NO_FREE,
    ST_UNDERFLOW,
    ST_OVERFLOW
  } status_t;

  typedef struct packed {
    logic [DEV_W-1:0] device;
    logic [BLK_W-1:0] block_number;
    logic [CNT_W-1:0] count;
    logic             cv;
  } entry_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_SCAN,
    RD_SLOT,
    RD_SWEEP
  } rd_mode_t;

  typedef struct packed {
    rd_mode_t rd_mode;
    logic     load_req;
    logic     get_commit;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_get;
    logic in_range;
    logic scan_last;
    logic sweep_needed;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_GET_FIN,
    S_SLOT_RD,
    S_SLOT_CHK,
    S_SWEEP,
    S_SWEEP_END,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/bclru_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface bclru_req_if;
  import bclru_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [DEV_W-1:0]  device;
  logic [BLK_W-1:0]  block_number;
  logic [SLOT_W-1:0] slot_in;

  modport source (output valid, op, device, block_number, slot_in, input ready);
  modport sink (input valid, op, device, block_number, slot_in, output ready);
endinterface

interface bclru_rsp_if;
  import bclru_pkg::*;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot_out;
  logic              hit;
  logic              needs_read;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  ref_count;

  modport source (output valid, slot_out, hit, needs_read, status, ref_count, input ready);
  modport sink (input valid, slot_out, hit, needs_read, status, ref_count, output ready);
endinterface
`default_nettype wire

// ===== hdl/bclru_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bclru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bclru_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bclru_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire bclru_pkg::dp_stat_t stat,
  output bclru_pkg::dp_cmd_t       cmd
);
  import bclru_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.rd_mode = RD_NONE;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          if (stat.is_get) begin
            state_next = S_SCAN;
          end else if (stat.in_range) begin
            state_next = S_SLOT_RD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        cmd.rd_mode = RD_SCAN;
        if (stat.scan_last) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_next = S_GET_FIN;
      end
      S_GET_FIN: begin
        cmd.get_commit = 1'b1;
        state_next     = S_DONE;
      end
      S_SLOT_RD: begin
        cmd.rd_mode = RD_SLOT;
        state_next  = S_SLOT_CHK;
      end
      S_SLOT_CHK: begin
        state_next = stat.sweep_needed ? S_SWEEP : S_DONE;
      end
      S_SWEEP: begin
        cmd.rd_mode = RD_SWEEP;
        if (stat.scan_last) begin
          state_next = S_SWEEP_END;
        end
      end
      S_SWEEP_END: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/bclru_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bclru_dp #(
  parameter int NUM_BUFFERS = bclru_pkg::NUM_BUFFERS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bclru_pkg::dp_cmd_t            cmd,
  output bclru_pkg::dp_stat_t                stat,
  input  wire logic [bclru_pkg::OP_W-1:0]    in_op,
  input  wire logic [bclru_pkg::DEV_W-1:0]   in_device,
  input  wire logic [bclru_pkg::BLK_W-1:0]   in_block_number,
  input  wire logic [bclru_pkg::SLOT_W-1:0]  in_slot,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [bclru_pkg::SLOT_W-1:0]  out_slot,
  output logic                               out_hit,
  output logic                               out_needs_read,
  output logic      [bclru_pkg::STAT_W-1:0]  out_status,
  output logic      [bclru_pkg::CNT_W-1:0]   out_ref_count
);
  import bclru_pkg::*;

  localparam int IW = $clog2(NUM_BUFFERS);
  localparam int EW = $bits(entry_t) + IW;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BUFFERS - 1);
  localparam logic [8:0]    NBUF9    = 9'(NUM_BUFFERS);

  // request
  op_t               req_op;
  logic [DEV_W-1:0]  req_dev;
  logic [BLK_W-1:0]  req_blk;
  logic [SLOT_W-1:0] req_slot;
  logic [8:0]        slot_ext;
  logic [IW-1:0]     slot_idx;

  // entry store
  logic [NUM_BUFFERS-1:0] ent_valid;
  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  logic [EW-1:0]          wr_data;
  logic                   rd_en;
  logic [IW-1:0]          rd_addr;
  logic [EW-1:0]          ram_q;
  rd_mode_t               rd_mode_q;
  logic [IW-1:0]          rd_addr_q;
  entry_t                 rd_entry;
  logic [IW-1:0]          rd_rank;
  logic [IW-1:0]          scan_idx;

  // scan trackers
  logic          hit_found;
  logic [IW-1:0] hit_idx;
  logic [IW-1:0] hit_rank;
  logic [CNT_W-1:0] hit_cnt;
  logic          hit_cv;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] free_rank;
  logic          tag_match;

  // slot op
  logic [CNT_W-1:0] slot_cnt_new;
  status_t          slot_status;
  logic [IW-1:0]    sweep_rank;
  logic [IW-1:0]    sweep_rank_new;
  entry_t           wr_entry;

  // result
  logic [SLOT_W-1:0] res_slot;
  logic              res_hit;
  logic              res_nread;
  status_t           res_status;
  logic [CNT_W-1:0]  res_cnt;
  logic [8:0]        hit_ext;
  logic [8:0]        free_ext;

  assign slot_ext = 9'(req_slot);
  assign slot_idx = slot_ext[IW-1:0];
  assign hit_ext  = 9'(hit_idx);
  assign free_ext = 9'(free_idx);

  assign stat.is_get       = (op_t'(in_op) == OP_GET);
  assign stat.in_range     = (9'(in_slot) < NBUF9);
  assign stat.scan_last    = (scan_idx == LAST_IDX);
  assign stat.out_free     = !out_valid || out_ready;
  assign stat.sweep_needed = (rd_mode_q == RD_SLOT) && (req_op == OP_RELEASE) &&
                             (rd_entry.count == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op   <= op_t'(in_op);
      req_dev  <= in_device;
      req_blk  <= in_block_number;
      req_slot <= in_slot;
    end
  end

  // read side
  assign rd_en   = (cmd.rd_mode != RD_NONE);
  assign rd_addr = (cmd.rd_mode == RD_SLOT) ? slot_idx : scan_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx  <= '0;
      rd_mode_q <= RD_NONE;
    end else begin
      rd_mode_q <= cmd.rd_mode;
      if ((cmd.rd_mode inside {RD_SCAN, RD_SWEEP}) && !stat.scan_last) begin
        scan_idx <= scan_idx + IW'(1);
      end else begin
        scan_idx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
  end

  // never-written entries read as their reset value
  always_comb begin
    if (ent_valid[rd_addr_q]) begin
      rd_entry = entry_t'(ram_q[EW-1:IW]);
      rd_rank  = ram_q[IW-1:0];
    end else begin
      rd_entry = '0;
      rd_rank  = LAST_IDX - rd_addr_q;
    end
  end

  bclru_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_BUFFERS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // scan trackers
  assign tag_match = (rd_entry.device == req_dev) && (rd_entry.block_number == req_blk);

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (rd_mode_q == RD_SCAN) begin
      if (tag_match && (!hit_found || rd_rank < hit_rank)) begin
        hit_found <= 1'b1;
        hit_idx   <= rd_addr_q;
        hit_rank  <= rd_rank;
        hit_cnt   <= rd_entry.count;
        hit_cv    <= rd_entry.cv;
      end
      if (rd_entry.count == '0 && (!free_found || rd_rank > free_rank)) begin
        free_found <= 1'b1;
        free_idx   <= rd_addr_q;
        free_rank  <= rd_rank;
      end
    end
  end

  // count update for release, pin, unpin
  always_comb begin
    slot_status  = ST_OK;
    slot_cnt_new = rd_entry.count;
    if (req_op == OP_PIN) begin
      if (rd_entry.count == CNT_MAX) begin
        slot_status = ST_OVERFLOW;
      end else begin
        slot_cnt_new = rd_entry.count + CNT_W'(1);
      end
    end else begin
      if (rd_entry.count == '0) begin
        slot_status = ST_UNDERFLOW;
      end else begin
        slot_cnt_new = rd_entry.count - CNT_W'(1);
      end
    end
  end

  always_comb begin
    if (rd_addr_q == slot_idx) begin
      sweep_rank_new = '0;
    end else if (rd_rank < sweep_rank) begin
      sweep_rank_new = rd_rank + IW'(1);
    end else begin
      sweep_rank_new = rd_rank;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_mode_q == RD_SLOT) begin
      sweep_rank <= rd_rank;
    end
  end

  // write side
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = rd_addr_q;
    wr_entry = rd_entry;
    wr_data  = {rd_entry, rd_rank};
    case (rd_mode_q)
      RD_SLOT: begin
        wr_en          = 1'b1;
        wr_entry.count = slot_cnt_new;
        wr_data        = {wr_entry, rd_rank};
      end
      RD_SWEEP: begin
        wr_en   = 1'b1;
        wr_data = {rd_entry, sweep_rank_new};
      end
      default: begin
        if (cmd.get_commit) begin
          wr_entry.device       = req_dev;
          wr_entry.block_number = req_blk;
          wr_entry.cv           = 1'b1;
          if (hit_found) begin
            wr_en          = (hit_cnt != CNT_MAX);
            wr_addr        = hit_idx;
            wr_entry.count = hit_cnt + CNT_W'(1);
            wr_data        = {wr_entry, hit_rank};
          end else begin
            wr_en          = free_found;
            wr_addr        = free_idx;
            wr_entry.count = CNT_W'(1);
            wr_data        = {wr_entry, free_rank};
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (wr_en) begin
      ent_valid[wr_addr] <= 1'b1;
    end
  end

  // result
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      res_slot   <= in_slot;
      res_hit    <= 1'b0;
      res_nread  <= 1'b0;
      res_status <= ST_OK;
      res_cnt    <= '0;
    end else if (rd_mode_q == RD_SLOT) begin
      res_status <= slot_status;
      res_cnt    <= slot_cnt_new;
    end else if (cmd.get_commit) begin
      if (hit_found) begin
        res_slot <= hit_ext[SLOT_W-1:0];
        res_hit  <= 1'b1;
        if (hit_cnt == CNT_MAX) begin
          res_status <= ST_OVERFLOW;
          res_cnt    <= CNT_MAX;
        end else begin
          res_nread <= !hit_cv;
          res_cnt   <= hit_cnt + CNT_W'(1);
        end
      end else if (free_found) begin
        res_slot  <= free_ext[SLOT_W-1:0];
        res_nread <= 1'b1;
        res_cnt   <= CNT_W'(1);
      end else begin
        res_slot   <= '0;
        res_status <= ST_NO_FREE;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_slot       <= res_slot;
      out_hit        <= res_hit;
      out_needs_read <= res_nread;
      out_status     <= res_status;
      out_ref_count  <= res_cnt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/block_cache_lru_refcount.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Payload                               | Handshake
// req     | in  | op, device, block_number, slot_in     | valid/ready
// rsp     | out | slot_out, hit, needs_read, status,    | valid/ready
//         |     | ref_count                             |
// A get scans every entry, one entry read per cycle from the entry RAM, which has separate
// read and write ports; release/pin/unpin read and rewrite one slot; a release that drops
// the count to zero adds a rank sweep over every entry; a slot out of range skips the RAM.
// Reset clears entry valid flags at once: no clearing pass, first item taken right after.
// One item in flight; req is taken again while a finished rsp item waits, and the
// next rsp item stalls in the engine until the output register frees.
module block_cache_lru_refcount #(
  parameter int NUM_BUFFERS = bclru_pkg::NUM_BUFFERS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  bclru_req_if.sink req,
  bclru_rsp_if.source rsp
);
  import bclru_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bclru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bclru_dp #(
    .NUM_BUFFERS (NUM_BUFFERS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_op           (req.op),
    .in_device       (req.device),
    .in_block_number (req.block_number),
    .in_slot         (req.slot_in),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_slot        (rsp.slot_out),
    .out_hit         (rsp.hit),
    .out_needs_read  (rsp.needs_read),
    .out_status      (rsp.status),
    .out_ref_count   (rsp.ref_count)
  );

endmodule
`default_nettype wire

// ===== hdl/bclru_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bclru_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          req_valid,
  input wire logic                          req_ready,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_ready,
  input wire logic [bclru_pkg::SLOT_W-1:0]  rsp_slot_out,
  input wire logic                          rsp_hit,
  input wire logic                          rsp_needs_read,
  input wire logic [bclru_pkg::STAT_W-1:0]  rsp_status,
  input wire logic [bclru_pkg::CNT_W-1:0]   rsp_ref_count
);
  import bclru_pkg::*;

  // one item in flight
  `ASSERT_NEXT(a_single_item, clk, rst, req_valid && req_ready, !req_ready, "req taken twice in a row")

  `ASSERT_NOW(a_ovf_count, clk, rst, rsp_valid && rsp_status == ST_OVERFLOW, rsp_ref_count == CNT_MAX && !rsp_needs_read, "overflow item with bad count")

  `ASSERT_NOW(a_no_free, clk, rst, rsp_valid && rsp_status == ST_NO_FREE, rsp_slot_out == '0 && rsp_ref_count == '0 && !rsp_hit && !rsp_needs_read, "no-free item not cleared")

  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_ref_count) && $stable(rsp_slot_out), "stalled rsp item changed")

endmodule

bind block_cache_lru_refcount bclru_checker u_bclru_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_slot_out   (rsp.slot_out),
  .rsp_hit        (rsp.hit),
  .rsp_needs_read (rsp.needs_read),
  .rsp_status     (rsp.status),
  .rsp_ref_count  (rsp.ref_count)
);
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import bclru_pkg::*;

  localparam int NB = NUM_BUFFERS_DEF;
  localparam int POOL = 40;

  typedef struct packed {
    op_t               op;
    logic [DEV_W-1:0]  device;
    logic [BLK_W-1:0]  block_number;
    logic [SLOT_W-1:0] slot_in;
  } cache_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic              hit;
    logic              needs_read;
    status_t           status;
    logic [CNT_W-1:0]  ref_count;
  } cache_rsp_t;

  logic clk;
  logic rst;

  bclru_req_if req();
  bclru_rsp_if rsp();

  block_cache_lru_refcount dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // shadow copy of the buffer pool
  logic [DEV_W-1:0] shadow_dev [NB];
  logic [BLK_W-1:0] shadow_blk [NB];
  logic [CNT_W-1:0] shadow_cnt [NB];
  logic             shadow_cv [NB];
  int unsigned      shadow_rank [NB];

  cache_req_t pending_requests[$];
  cache_rsp_t expected_replies[$];
  int issued_count;
  int accepted_count;
  int failure_count;

  logic req_taken;
  int send_gap;
  int stall_left;
  bit req_calm;
  bit rsp_calm;

  logic [DEV_W-1:0] pool_dev [POOL];
  logic [BLK_W-1:0] pool_blk [POOL];

  function automatic cache_rsp_t apply_cache_op(cache_req_t r);
    cache_rsp_t o;
    bit found;
    int best;
    int unsigned best_rank;
    int unsigned old_rank;
    int s;
    o = '0;
    o.status = ST_OK;
    found = 0;
    best = 0;
    best_rank = 0;
    if (r.op == OP_GET) begin
      for (int i = 0; i < NB; i++) begin
        if (shadow_dev[i] == r.device && shadow_blk[i] == r.block_number &&
            (!found || shadow_rank[i] < best_rank)) begin
          found = 1;
          best = i;
          best_rank = shadow_rank[i];
        end
      end
      if (found) begin
        o.slot_out = SLOT_W'(best);
        o.hit = 1'b1;
        if (shadow_cnt[best] == CNT_MAX) begin
          o.status = ST_OVERFLOW;
          o.ref_count = CNT_MAX;
        end else begin
          o.needs_read = !shadow_cv[best];
          shadow_cnt[best] = shadow_cnt[best] + 1'b1;
          shadow_cv[best] = 1'b1;
          o.ref_count = shadow_cnt[best];
        end
      end else begin
        // recycle the least recent idle entry
        for (int i = 0; i < NB; i++) begin
          if (shadow_cnt[i] == 0 && (!found || shadow_rank[i] > best_rank)) begin
            found = 1;
            best = i;
            best_rank = shadow_rank[i];
          end
        end
        if (found) begin
          shadow_dev[best] = r.device;
          shadow_blk[best] = r.block_number;
          shadow_cnt[best] = CNT_W'(1);
          shadow_cv[best] = 1'b1;
          o.slot_out = SLOT_W'(best);
          o.needs_read = 1'b1;
          o.ref_count = CNT_W'(1);
        end else begin
          o.status = ST_NO_FREE;
        end
      end
    end else begin
      s = int'(r.slot_in);
      o.slot_out = r.slot_in;
      if (s < NB) begin
        if (r.op == OP_PIN) begin
          if (shadow_cnt[s] == CNT_MAX) o.status = ST_OVERFLOW;
          else shadow_cnt[s] = shadow_cnt[s] + 1'b1;
        end else if (shadow_cnt[s] == 0) begin
          o.status = ST_UNDERFLOW;
        end else begin
          shadow_cnt[s] = shadow_cnt[s] - 1'b1;
          if (r.op == OP_RELEASE && shadow_cnt[s] == 0) begin
            old_rank = shadow_rank[s];
            for (int i = 0; i < NB; i++) begin
              if (shadow_rank[i] < old_rank) shadow_rank[i] = shadow_rank[i] + 1;
            end
            shadow_rank[s] = 0;
          end
        end
        o.ref_count = shadow_cnt[s];
      end
    end
    return o;
  endfunction

  function automatic string fmt_reply(cache_rsp_t r);
    return $sformatf("slot=%0d hit=%0b read=%0b status=%0d count=%0d",
                     r.slot_out, r.hit, r.needs_read, r.status, r.ref_count);
  endfunction

  function automatic void note_failure(string msg);
    failure_count++;
    if (failure_count <= 10) $display("%t: %s", $realtime, msg);
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [SLOT_W-1:0] pick_held_slot();
    int held[$];
    for (int i = 0; i < NB; i++) begin
      if (shadow_cnt[i] != 0) held.push_back(i);
    end
    if (held.size() == 0 || $urandom_range(0, 9) == 0) begin
      return SLOT_W'($urandom_range(0, NB - 1));
    end
    return SLOT_W'(held[$urandom_range(0, held.size() - 1)]);
  endfunction

  task automatic queue_req(op_t op, logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk,
                           logic [SLOT_W-1:0] slot);
    cache_req_t it;
    while (pending_requests.size() >= 2) @(negedge clk);
    it.op = op;
    it.device = dev;
    it.block_number = blk;
    it.slot_in = slot;
    pending_requests.push_back(it);
    issued_count++;
  endtask

  task automatic get_block(logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk);
    queue_req(OP_GET, dev, blk, SLOT_W'($urandom_range(0, NB - 1)));
  endtask

  task automatic slot_op(op_t op, logic [SLOT_W-1:0] slot);
    queue_req(op, DEV_W'($urandom), $urandom, slot);
  endtask

  task automatic wait_all_replied();
    while (accepted_count != issued_count || expected_replies.size() != 0) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // request driver
  always @(negedge clk) begin
    cache_req_t it;
    if ($urandom_range(0, 199) == 0) req_calm <= !req_calm;
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req.valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        it = pending_requests.pop_front();
        req.valid <= 1'b1;
        req.op <= it.op;
        req.device <= it.device;
        req.block_number <= it.block_number;
        req.slot_in <= it.slot_in;
        send_gap <= req_calm ? 0 : pick_gap();
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // reply back-pressure
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) rsp_calm <= !rsp_calm;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp.ready <= 1'b0;
    end else if (!rsp_calm && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // monitor: predict on accepted requests, check accepted replies
  always @(posedge clk) begin
    cache_req_t it;
    cache_rsp_t got;
    cache_rsp_t want;
    if (rst) begin
      req_taken <= 1'b0;
      for (int i = 0; i < NB; i++) begin
        shadow_dev[i] = '0;
        shadow_blk[i] = '0;
        shadow_cnt[i] = '0;
        shadow_cv[i] = 1'b0;
        shadow_rank[i] = NB - 1 - i;
      end
    end else begin
      req_taken <= req.valid && req.ready;
      if (req.valid && req.ready) begin
        it.op = op_t'(req.op);
        it.device = req.device;
        it.block_number = req.block_number;
        it.slot_in = req.slot_in;
        expected_replies.push_back(apply_cache_op(it));
        accepted_count++;
      end
      if (rsp.valid && rsp.ready) begin
        got.slot_out = rsp.slot_out;
        got.hit = rsp.hit;
        got.needs_read = rsp.needs_read;
        got.status = status_t'(rsp.status);
        got.ref_count = rsp.ref_count;
        if (expected_replies.size() == 0) begin
          note_failure({"unexpected reply ", fmt_reply(got)});
        end else begin
          want = expected_replies.pop_front();
          if (got !== want)
            note_failure({"reply mismatch: expected ", fmt_reply(want), " got ", fmt_reply(got)});
        end
      end
    end
  end

  initial begin
    int k;
    int unsigned r;
    int c;
    rst = 1'b1;
    req.valid = 1'b0;
    req.op = '0;
    req.device = '0;
    req.block_number = '0;
    req.slot_in = '0;
    rsp.ready = 1'b0;
    issued_count = 0;
    accepted_count = 0;
    failure_count = 0;
    send_gap = 0;
    stall_left = 0;
    req_calm = 0;
    rsp_calm = 0;
    for (int i = 0; i < POOL; i++) begin
      pool_dev[i] = DEV_W'($urandom);
      pool_blk[i] = $urandom;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset tags are all zero: first get hits but still needs a read
    get_block(16'h0000, 32'h0000_0000);
    get_block(16'h0000, 32'h0000_0000);
    get_block(16'hFFFF, 32'hFFFF_FFFF);
    get_block(16'hFFFF, 32'hFFFF_FFFF);
    slot_op(OP_RELEASE, 0);
    slot_op(OP_RELEASE, 0);
    slot_op(OP_RELEASE, 0);
    slot_op(OP_UNPIN, 5);
    slot_op(OP_PIN, 5);
    slot_op(OP_UNPIN, 5);
    slot_op(OP_PIN, 31);
    slot_op(OP_UNPIN, 31);
    get_block(16'hAAAA, 32'h5555_5555);
    get_block(16'h5555, 32'hAAAA_AAAA);
    get_block(16'h0000, 32'h0000_0000);
    slot_op(OP_RELEASE, 31);

    // saturate one count, then overflow through pin and through a get hit
    while (shadow_cnt[31] != CNT_MAX) slot_op(OP_PIN, 31);
    wait_all_replied();
    slot_op(OP_PIN, 31);
    get_block(16'h0000, 32'h0000_0000);

    // exhaust the pool
    repeat (34) get_block(DEV_W'($urandom), $urandom);
    wait_all_replied();
    for (int s = 0; s < NB - 1; s++) begin
      c = int'(shadow_cnt[s]);
      repeat (c) slot_op(OP_RELEASE, SLOT_W'(s));
    end

    for (int n = 0; n < 440; n++) begin
      if (n == 220) wait_all_replied();
      r = $urandom_range(0, 99);
      if (r < 40) begin
        if ($urandom_range(0, 99) < 85) begin
          k = $urandom_range(0, POOL - 1);
          get_block(pool_dev[k], pool_blk[k]);
        end else begin
          get_block(DEV_W'($urandom), $urandom);
        end
      end else if (r < 75) begin
        slot_op(OP_RELEASE, pick_held_slot());
      end else if (r < 85) begin
        slot_op(OP_PIN, pick_held_slot());
      end else begin
        slot_op(OP_UNPIN, pick_held_slot());
      end
    end

    wait_all_replied();
    repeat (2 * NB) @(posedge clk);
    if (failure_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bclru_pkg.sv
hdl/bclru_if.sv
hdl/bclru_ram.sv
hdl/bclru_ctrl.sv
hdl/bclru_dp.sv
hdl/block_cache_lru_refcount.sv
hdl/bclru_checker.sv
bench/testbench.sv
